// ===== rtl/core/r2nv12_pkg.sv =====
package r2nv12_pkg;

   // Frame size limits and counter width.
   localparam int MAX_WIDTH  = 4096;
   localparam int MAX_HEIGHT = 4096;
   localparam int COUNT_W    = 12;

   // Field widths.
   localparam int PIX_W       = 8;
   localparam int SIZE_W      = 13;
   localparam int STRIDE_W    = 15;
   localparam int ADDR_W      = 27;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 15;

   // BT.601 integer coefficients.
   localparam int COEF_Y_R  = 66;
   localparam int COEF_Y_G  = 129;
   localparam int COEF_Y_B  = 25;
   localparam int COEF_U_R  = 38;
   localparam int COEF_U_G  = 74;
   localparam int COEF_U_B  = 112;
   localparam int COEF_V_R  = 112;
   localparam int COEF_V_G  = 94;
   localparam int COEF_V_B  = 18;
   localparam int ROUND_ADD = 128;
   localparam int Y_OFFSET  = 16;
   // 128 << 8 added before the shift gives the +128 chroma offset and
   // keeps the sum positive.
   localparam int CHROMA_BIAS = 32768;
   localparam int SUM_W       = 16;

   // Register reset values.
   localparam logic [SIZE_W-1:0]   WIDTH_RESET  = SIZE_W'(1920);
   localparam logic [SIZE_W-1:0]   HEIGHT_RESET = SIZE_W'(1080);
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(1920);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_OUT_STRIDE   = 2'd2
   } csr_index_type;

   // Converted color of one pixel.
   typedef struct packed {
      logic [PIX_W-1:0] y;
      logic [PIX_W-1:0] u;
      logic [PIX_W-1:0] v;
   } pix_yuv_type;

endpackage

// ===== rtl/core/r2nv12_if.sv =====
// Pixel input channel.
interface r2nv12_req_if import r2nv12_pkg::*;;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] blue;
   logic [PIX_W-1:0] green;
   logic [PIX_W-1:0] red;

   modport source (output valid, blue, green, red, input ready);
   modport sink   (input valid, blue, green, red, output ready);
endinterface

// Result channel: luma and chroma writes.
interface r2nv12_rsp_if import r2nv12_pkg::*;;
   logic              valid;
   logic              ready;
   logic              y_write;
   logic [PIX_W-1:0]  y_value;
   logic [ADDR_W-1:0] y_addr;
   logic              uv_write;
   logic [PIX_W-1:0]  u_value;
   logic [PIX_W-1:0]  v_value;
   logic [ADDR_W-1:0] uv_addr;
   logic              frame_last;

   modport source (output valid, y_write, y_value, y_addr, uv_write, u_value, v_value,
                   uv_addr, frame_last, input ready);
   modport sink   (input valid, y_write, y_value, y_addr, uv_write, u_value, v_value,
                   uv_addr, frame_last, output ready);
endinterface

// Configuration write channel.
interface r2nv12_csr_if import r2nv12_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rgb_to_nv12_converter_core.sv =====
// Channel   Port       Direction  Beat contents
// pixels    req_chan   in         blue, green, red
// writes    rsp_chan   out        y_write, y_value, y_addr, uv_write, u_value,
//                                 v_value, uv_addr, frame_last
// config    csr_chan   in         index, data (always ready)
//
// One pixel per clock sustained while rsp_chan takes beats. A beat passes the first stage
// and then the output register before it appears on rsp_chan: the first stage forms the
// color sums and the row times stride products, the second adds the column into both
// addresses and drives the output register.
// Synchronous reset returns the registers to 1920 x 1080, stride 1920, and clears the
// counters and valids. A stall on rsp_chan holds the output register; the first stage
// still takes a beat while it is empty, so req_chan.ready drops in the same cycle only
// when both stages are full.
module rgb_to_nv12_converter_core import r2nv12_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   r2nv12_req_if.sink   req_chan,
   r2nv12_rsp_if.source rsp_chan,
   r2nv12_csr_if.sink   csr_chan
);

   localparam logic [SIZE_W-1:0] MAX_WIDTH_C  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_C = SIZE_W'(MAX_HEIGHT);
   localparam logic [SIZE_W-1:0] MIN_SIZE_C   = SIZE_W'(2);
   localparam int CROW_W = SIZE_W + 1;

   // First stage contents.
   typedef struct packed {
      logic                y_write;
      logic                uv_write;
      logic                frame_last;
      logic [COUNT_W-1:0]  col;
      logic [ADDR_W-1:0]   y_base;
      logic [ADDR_W-1:0]   uv_base;
      pix_yuv_type         yuv;
   } stage_type;

   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [COUNT_W-1:0]  col_ff, col_in;
   logic [COUNT_W-1:0]  row_ff, row_in;

   logic                s1_valid_ff;
   stage_type           s1_ff, s1_in;
   logic                rsp_valid_ff;
   logic                y_write_ff;
   logic [PIX_W-1:0]    y_value_ff;
   logic [ADDR_W-1:0]   y_addr_ff;
   logic                uv_write_ff;
   logic [PIX_W-1:0]    u_value_ff;
   logic [PIX_W-1:0]    v_value_ff;
   logic [ADDR_W-1:0]   uv_addr_ff;
   logic                frame_last_ff;

   logic [SIZE_W-1:0]   width_even;
   logic [SIZE_W-1:0]   width_clamp;
   logic [SIZE_W-1:0]   width_eff;
   logic [SIZE_W-1:0]   height_eff;
   logic                row_end;
   logic                frame_end;
   logic                in_pairs;
   logic [CROW_W-1:0]   chroma_row;
   logic [COUNT_W+STRIDE_W-1:0] y_prod;
   logic [CROW_W+STRIDE_W-1:0]  uv_prod;
   pix_yuv_type         yuv;

   logic rsp_load;
   logic s1_load;
   logic req_accept;

   // Handshake: each stage loads when it is empty or its successor moves.
   assign rsp_load       = !rsp_valid_ff || rsp_chan.ready;
   assign s1_load        = !s1_valid_ff || rsp_load;
   assign req_chan.ready = s1_load;
   assign req_accept     = req_chan.valid && s1_load;
   assign csr_chan.ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         stride_ff <= STRIDE_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_chan.data[SIZE_W-1:0];
            CSR_FRAME_HEIGHT: height_ff <= csr_chan.data[SIZE_W-1:0];
            CSR_OUT_STRIDE:   stride_ff <= csr_chan.data[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size: width forced even, both clamped to the supported range.
   always_comb begin
      width_even = {width_ff[SIZE_W-1:1], 1'b0};
      if (width_even < MIN_SIZE_C) begin
         width_clamp = MIN_SIZE_C;
      end else if (width_even > MAX_WIDTH_C) begin
         width_clamp = MAX_WIDTH_C;
      end else begin
         width_clamp = width_even;
      end
      width_eff = {width_clamp[SIZE_W-1:1], 1'b0};

      if (height_ff < MIN_SIZE_C) begin
         height_eff = MIN_SIZE_C;
      end else if (height_ff > MAX_HEIGHT_C) begin
         height_eff = MAX_HEIGHT_C;
      end else begin
         height_eff = height_ff;
      end
   end

   // Position decode for the pixel now at the input.
   assign row_end   = {1'b0, col_ff} >= (width_eff - SIZE_W'(1));
   assign frame_end = row_end && ({1'b0, row_ff} >= (height_eff - SIZE_W'(1)));
   assign in_pairs  = {1'b0, row_ff} < {height_eff[SIZE_W-1:1], 1'b0};

   // Raster counters.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (frame_end) begin
         col_in = '0;
         row_in = '0;
      end else if (row_end) begin
         col_in = '0;
         row_in = row_ff + COUNT_W'(1);
      end else begin
         col_in = col_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Color conversion.
   r2nv12_color u_color (
      .blue  (req_chan.blue),
      .green (req_chan.green),
      .red   (req_chan.red),
      .yuv   (yuv)
   );

   // Row base products for the luma and chroma planes.
   assign chroma_row = CROW_W'(row_ff[COUNT_W-1:1]) + CROW_W'(height_eff);
   assign y_prod     = (COUNT_W+STRIDE_W)'(row_ff) * (COUNT_W+STRIDE_W)'(stride_ff);
   assign uv_prod    = (CROW_W+STRIDE_W)'(chroma_row) * (CROW_W+STRIDE_W)'(stride_ff);

   always_comb begin
      s1_in.y_write    = in_pairs;
      s1_in.uv_write   = in_pairs && row_ff[0] && !col_ff[0];
      s1_in.frame_last = frame_end;
      s1_in.col        = col_ff;
      s1_in.y_base     = ADDR_W'(y_prod);
      s1_in.uv_base    = ADDR_W'(uv_prod);
      s1_in.yuv        = yuv;
   end

   // First stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_load) begin
         s1_valid_ff <= req_accept;
      end
      if (req_accept) begin
         s1_ff <= s1_in;
      end
   end

   // Output register: add the column and blank fields that are not written.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (rsp_load && s1_valid_ff) begin
         y_write_ff    <= s1_ff.y_write;
         uv_write_ff   <= s1_ff.uv_write;
         frame_last_ff <= s1_ff.frame_last;
         y_value_ff    <= s1_ff.y_write ? s1_ff.yuv.y : '0;
         y_addr_ff     <= s1_ff.y_write ? s1_ff.y_base + ADDR_W'(s1_ff.col) : '0;
         u_value_ff    <= s1_ff.uv_write ? s1_ff.yuv.u : '0;
         v_value_ff    <= s1_ff.uv_write ? s1_ff.yuv.v : '0;
         uv_addr_ff    <= s1_ff.uv_write ? s1_ff.uv_base + ADDR_W'(s1_ff.col) : '0;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.y_write    = y_write_ff;
   assign rsp_chan.y_value    = y_value_ff;
   assign rsp_chan.y_addr     = y_addr_ff;
   assign rsp_chan.uv_write   = uv_write_ff;
   assign rsp_chan.u_value    = u_value_ff;
   assign rsp_chan.v_value    = v_value_ff;
   assign rsp_chan.uv_addr    = uv_addr_ff;
   assign rsp_chan.frame_last = frame_last_ff;

endmodule

// ===== rtl/core/r2nv12_color.sv =====
module r2nv12_color import r2nv12_pkg::*; (
   input  logic [PIX_W-1:0] blue,
   input  logic [PIX_W-1:0] green,
   input  logic [PIX_W-1:0] red,
   output pix_yuv_type      yuv
);

   logic [SUM_W-1:0] y_sum;
   logic [SUM_W-1:0] u_sum;
   logic [SUM_W-1:0] v_sum;

   // Weighted sums. The chroma sums stay within 16 bits once the bias is
   // added, so intermediate wrap in the subtraction cancels out.
   assign y_sum = SUM_W'(COEF_Y_R * red) + SUM_W'(COEF_Y_G * green)
                + SUM_W'(COEF_Y_B * blue) + SUM_W'(ROUND_ADD);
   assign u_sum = SUM_W'(COEF_U_B * blue) + SUM_W'(ROUND_ADD + CHROMA_BIAS)
                - SUM_W'(COEF_U_R * red) - SUM_W'(COEF_U_G * green);
   assign v_sum = SUM_W'(COEF_V_R * red) + SUM_W'(ROUND_ADD + CHROMA_BIAS)
                - SUM_W'(COEF_V_G * green) - SUM_W'(COEF_V_B * blue);

   // Divide by 256 and add the luma offset.
   assign yuv.y = y_sum[SUM_W-1:SUM_W-PIX_W] + PIX_W'(Y_OFFSET);
   assign yuv.u = u_sum[SUM_W-1:SUM_W-PIX_W];
   assign yuv.v = v_sum[SUM_W-1:SUM_W-PIX_W];

endmodule
